@@ rtl/sbdm_pkg.sv @@
// ---------------------------------------------------------------------------
// sbdm_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// single-bin DFT magnitude block.
// ---------------------------------------------------------------------------
package sbdm_pkg;

	// field and register widths
	localparam int FREQ_W      = 15;
	localparam int RATE_W      = 18;
	localparam int LEN_W       = 13;
	localparam int CFG_CNT_W   = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 18;
	localparam int SAMPLE_W    = 16;
	localparam int LEVEL_W     = 27;
	localparam int SUM_W       = 48;
	localparam int PHASE_W     = 12;
	localparam int BIN_W       = 14;   // holds the saturated bin 2*FRAME_MAX
	localparam int CHAN_CNT_W  = 5;    // holds a channel count up to 16
	localparam int CHAN_IDX_W  = 4;    // holds a channel index up to 15
	localparam int FRAME_MAX   = 4096;
	localparam int QS_LEN      = 1025;
	localparam int QS_AW       = 11;
	localparam int QS_W        = 16;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_FIFO_DEPTH   = 4;

	localparam logic [BIN_W-1:0] BIN_SAT = BIN_W'(2 * FRAME_MAX);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FREQ   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVED   = 3'd4;

	// register reset values
	localparam logic [FREQ_W-1:0]    RST_TARGET_FREQ   = 15'd2000;
	localparam logic [RATE_W-1:0]    RST_SAMPLE_RATE   = 18'd44100;
	localparam logic [LEN_W-1:0]     RST_FRAME_LENGTH  = 13'd1024;
	localparam logic [CFG_CNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
	localparam logic                 RST_INTERLEAVED   = 1'b1;

	// end-of-frame result kinds
	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_NYQ  = 2'd1;
	localparam logic [1:0] RES_MAG  = 2'd2;

	typedef struct packed {
		logic [FREQ_W-1:0]    target_freq;
		logic [RATE_W-1:0]    sample_rate;
		logic [LEN_W-1:0]     frame_length;
		logic [CFG_CNT_W-1:0] channel_count;
		logic                 interleaved;
	} sbdm_cfg_t;

	// one queued operation from the front end to the back end
	typedef struct packed {
		logic [SAMPLE_W-1:0]   x;
		logic [PHASE_W-1:0]    phase;
		logic [CHAN_IDX_W-1:0] chan;
		logic [CHAN_CNT_W-1:0] chans;
		logic                  clr;    // clear all sums first
		logic                  acc;    // accumulate x into chan
		logic                  last;   // emit a result afterwards
		logic [1:0]            kind;
	} sbdm_entry_t;

	typedef logic [QS_W-1:0] qsin_tab_t [0:QS_LEN-1];

	// quarter-wave sine, Taylor series to x^13 in Q30, rounded to Q15
	function automatic qsin_tab_t qsin_build();
		qsin_tab_t       tab;
		longint unsigned theta;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned scaled;
		longint          acc;
		int              i;
		int              n;
		for (i = 0; i < QS_LEN; i++) begin
			theta = (64'(i) * 64'd6746518852 + 64'd2048) >> 12;
			x2    = (theta * theta + (64'd1 << 29)) >> 30;
			term  = theta;
			acc   = longint'(theta);
			for (n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) acc = acc - longint'(term);
				else acc = acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			scaled = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
			tab[i] = scaled[QS_W-1:0];
		end
		return tab;
	endfunction

endpackage

@@ rtl/sbdm_div.sv @@
// ---------------------------------------------------------------------------
// sbdm_div
// Restoring divider, one quotient bit per cycle. Result valid on done.
// ---------------------------------------------------------------------------
module sbdm_div #(
	parameter int DW = 35,
	parameter int VW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   shifted;
	logic [VW+1:0] diff;
	logic          ge;

	// trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = ~diff[VW+1];

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/sbdm_fifo.sv @@
// ---------------------------------------------------------------------------
// sbdm_fifo
// Small register queue between the front end and the back end.
// ---------------------------------------------------------------------------
module sbdm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	assign pop_data = mem_q[rd_q];
	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ rtl/sbdm_front.sv @@
// ---------------------------------------------------------------------------
// sbdm_front
// Accepts samples, tracks frame position, latches the bin at frame start
// and works out the table phase, then queues one operation per sample.
// ---------------------------------------------------------------------------
module sbdm_front import sbdm_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sbdm_cfg_t           cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                push,
	output sbdm_entry_t         push_data,
	input  logic                full
);
	localparam int PH_PROD_W = 23;                    // bin*n below 2^23
	localparam int DIV_DW    = PH_PROD_W + PHASE_W;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_BIN  = 3'd1;
	localparam logic [2:0] F_EVAL = 3'd2;
	localparam logic [2:0] F_MUL  = 3'd3;
	localparam logic [2:0] F_PDIV = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	logic [2:0]             state_q;
	logic [LEN_W-1:0]       sp_q;
	logic [CHAN_CNT_W-1:0]  cp_q;
	logic [BIN_W-1:0]       bin_q;
	logic [PH_PROD_W-1:0]   mul_q;
	sbdm_entry_t            ent_q;

	logic [LEN_W-1:0]       len;
	logic [CHAN_CNT_W-1:0]  chans;
	logic [CHAN_CNT_W-1:0]  cnt_ext;
	logic                   accept;
	logic                   oor;
	logic [LEN_W-1:0]       sp_eff;
	logic [CHAN_CNT_W-1:0]  cp_eff;
	logic                   frame_start;
	logic                   active;
	logic [LEN_W-1:0]       sp_inc;
	logic [CHAN_CNT_W-1:0]  cp_inc;
	logic [LEN_W-1:0]       sp_n;
	logic [CHAN_CNT_W-1:0]  cp_n;
	logic                   done_n;
	logic [FREQ_W+LEN_W-1:0] bin_num;
	logic [BIN_W+LEN_W-1:0]  prod_full;

	logic                   div_start;
	logic [DIV_DW-1:0]      div_dividend;
	logic [RATE_W-1:0]      div_divisor;
	logic                   div_busy;
	logic                   div_done;
	logic [DIV_DW-1:0]      div_quot;

	// clamp frame length and channel count
	always_comb begin
		cnt_ext = {1'b0, cfg.channel_count};
		len = (cfg.frame_length > LEN_W'(FRAME_MAX)) ? LEN_W'(FRAME_MAX) : cfg.frame_length;
		if (cnt_ext == '0) chans = CHAN_CNT_W'(1);
		else if (cnt_ext > CHAN_CNT_W'(MAX_CHANNELS)) chans = CHAN_CNT_W'(MAX_CHANNELS);
		else chans = cnt_ext;
	end

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;

	// positions, dropped partial frame restarts at zero
	assign oor         = (sp_q >= len) || (cp_q >= chans);
	assign sp_eff      = oor ? '0 : sp_q;
	assign cp_eff      = oor ? '0 : cp_q;
	assign frame_start = (sp_eff == '0) && (cp_eff == '0);
	assign active      = (bin_q <= {2'b00, len[LEN_W-1:1]});

	// next position after this sample, back to zero at frame end
	always_comb begin
		sp_inc = sp_q + 1'b1;
		cp_inc = cp_q + 1'b1;
		sp_n   = sp_q;
		cp_n   = cp_q;
		done_n = 1'b0;
		if (cfg.interleaved) begin
			if (cp_inc >= chans) begin
				cp_n   = '0;
				sp_n   = sp_inc;
				done_n = (sp_inc >= len);
			end else begin
				cp_n = cp_inc;
			end
		end else begin
			if (sp_inc >= len) begin
				sp_n   = '0;
				cp_n   = cp_inc;
				done_n = (cp_inc >= chans);
			end else begin
				sp_n = sp_inc;
			end
		end
		if (done_n) begin
			sp_n = '0;
			cp_n = '0;
		end
	end

	// divider operand select: bin at frame start, phase per sample
	assign bin_num   = cfg.target_freq * len;
	assign prod_full = bin_q * sp_q;
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_DW'(bin_num);
		div_divisor  = cfg.sample_rate;
		if (state_q == F_MUL) begin
			div_start    = 1'b1;
			div_dividend = {mul_q, {PHASE_W{1'b0}}};
			div_divisor  = RATE_W'(len);
		end else if (accept && len != '0 && frame_start && cfg.sample_rate != '0) begin
			div_start = 1'b1;
		end
	end

	sbdm_div #(
		.DW (DIV_DW),
		.VW (RATE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			sp_q    <= '0;
			cp_q    <= '0;
			bin_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (len == '0) begin
							sp_q    <= '0;
							cp_q    <= '0;
							state_q <= F_PUSH;
						end else begin
							sp_q <= sp_eff;
							cp_q <= cp_eff;
							if (frame_start && cfg.sample_rate != '0) begin
								state_q <= F_BIN;
							end else begin
								if (frame_start) bin_q <= BIN_SAT;
								state_q <= F_EVAL;
							end
						end
					end
				end
				F_BIN: begin
					if (div_done) begin
						bin_q   <= (div_quot > DIV_DW'(BIN_SAT)) ? BIN_SAT : div_quot[BIN_W-1:0];
						state_q <= F_EVAL;
					end
				end
				F_EVAL: begin
					sp_q    <= sp_n;
					cp_q    <= cp_n;
					state_q <= active ? F_MUL : F_PUSH;
				end
				F_MUL: begin
					state_q <= F_PDIV;
				end
				F_PDIV: begin
					if (div_done) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// queued operation fields
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q.x     <= sample;
			ent_q.phase <= '0;
			ent_q.chans <= chans;
			ent_q.chan  <= cp_eff[CHAN_IDX_W-1:0];
			ent_q.clr   <= 1'b1;
			ent_q.acc   <= 1'b0;
			ent_q.last  <= 1'b1;
			ent_q.kind  <= RES_ZERO;
			if (len != '0) begin
				ent_q.clr  <= frame_start;
				ent_q.last <= 1'b0;
			end
		end
		if (state_q == F_EVAL) begin
			mul_q      <= prod_full[PH_PROD_W-1:0];
			ent_q.acc  <= active;
			ent_q.last <= done_n;
			ent_q.kind <= active ? RES_MAG : RES_NYQ;
		end
		if (state_q == F_PDIV && div_done) ent_q.phase <= div_quot[PHASE_W-1:0];
	end

	assign push      = (state_q == F_PUSH) && !full;
	assign push_data = ent_q;

	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !div_busy)
		else $error("sample taken while divider busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == F_BIN || state_q == F_PDIV))
		else $error("divider finished in unexpected state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && len == '0) |=> (state_q == F_PUSH))
		else $error("empty frame did not queue a result");

endmodule

@@ rtl/sbdm_back.sv @@
// ---------------------------------------------------------------------------
// sbdm_back
// Executes queued operations: sine lookup, multiply-accumulate per channel,
// and at frame end the channel magnitudes, their average and the result.
// ---------------------------------------------------------------------------
module sbdm_back import sbdm_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbdm_entry_t        head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] level,
	output logic               above_nyquist
);
	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int TOT_W = 32 + $clog2(MAX_CHANNELS);
	localparam int SQ_W  = 2 * SUM_W;

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_MUL   = 4'd1;
	localparam logic [3:0] B_ACC   = 4'd2;
	localparam logic [3:0] B_FIN   = 4'd3;
	localparam logic [3:0] B_MLOAD = 4'd4;
	localparam logic [3:0] B_MMUL  = 4'd5;
	localparam logic [3:0] B_MADD  = 4'd6;
	localparam logic [3:0] B_SQ0   = 4'd7;
	localparam logic [3:0] B_SQRT  = 4'd8;
	localparam logic [3:0] B_NEXT  = 4'd9;
	localparam logic [3:0] B_DIV   = 4'd10;
	localparam logic [3:0] B_OUT   = 4'd11;

	localparam qsin_tab_t QSIN = qsin_build();

	logic [3:0]               state_q;
	sbdm_entry_t              ent_q;
	logic [SUM_W-1:0]         re_q [MAX_CHANNELS];
	logic [SUM_W-1:0]         im_q [MAX_CHANNELS];
	logic [QS_W-1:0]          rom_c_q;
	logic [QS_W-1:0]          rom_s_q;
	logic                     neg_c_q;
	logic                     neg_s_q;
	logic signed [32:0]       pc_q;
	logic signed [32:0]       ps_q;
	logic [CHAN_CNT_W-1:0]    c_q;
	logic [SUM_W-1:0]         ar_q;
	logic [SUM_W-1:0]         ai_q;
	logic [2:0]               step_q;
	logic [SUM_W-1:0]         prod_q;
	logic [SQ_W-1:0]          sq_q;
	logic [63:0]              y_q;
	logic [63:0]              r_q;
	logic [63:0]              bit_q;
	logic [TOT_W-1:0]         tot_q;
	logic [LEVEL_W-1:0]       res_level_q;
	logic                     res_nyq_q;
	logic                     out_valid_q;
	logic [LEVEL_W-1:0]       level_q;
	logic                     nyq_q;

	logic [PHASE_W-1:0]       cos_idx;
	logic [QS_AW-1:0]         addr_c;
	logic [QS_AW-1:0]         addr_s;
	logic signed [QS_W:0]     cos_v;
	logic signed [QS_W:0]     sin_v;
	logic                     clr_now;
	logic [SUM_W-1:0]         re_sel;
	logic [SUM_W-1:0]         im_sel;
	logic [23:0]              op_a;
	logic [23:0]              op_b;
	logic [SUM_W-1:0]         prod_full;
	logic [SQ_W-1:0]          sq_term;
	logic [63:0]              rb_sum;
	logic                     ld_out;
	logic                     div_start;
	logic                     avg_busy;
	logic                     div_done;
	logic [TOT_W-1:0]         div_quot;

	assign pop     = (state_q == B_IDLE) && !empty;
	assign clr_now = pop && head.clr;

	// quarter-wave table addresses for sine and cosine of the head phase
	always_comb begin
		cos_idx = head.phase + PHASE_W'(1024);
		addr_s  = head.phase[10] ? QS_AW'(11'd1024 - {1'b0, head.phase[9:0]})
		                         : {1'b0, head.phase[9:0]};
		addr_c  = cos_idx[10] ? QS_AW'(11'd1024 - {1'b0, cos_idx[9:0]})
		                      : {1'b0, cos_idx[9:0]};
	end

	// table read, registered
	always_ff @(posedge clk) begin
		rom_s_q <= QSIN[addr_s];
		rom_c_q <= QSIN[addr_c];
		neg_s_q <= head.phase[11];
		neg_c_q <= cos_idx[11];
	end

	assign cos_v = neg_c_q ? -$signed({1'b0, rom_c_q}) : $signed({1'b0, rom_c_q});
	assign sin_v = neg_s_q ? -$signed({1'b0, rom_s_q}) : $signed({1'b0, rom_s_q});

	// per-channel sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				re_q[i] <= '0;
				im_q[i] <= '0;
			end
		end else if (clr_now) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				re_q[i] <= '0;
				im_q[i] <= '0;
			end
		end else if (state_q == B_ACC) begin
			re_q[ent_q.chan[CH_W-1:0]] <= re_q[ent_q.chan[CH_W-1:0]] + SUM_W'(pc_q);
			im_q[ent_q.chan[CH_W-1:0]] <= im_q[ent_q.chan[CH_W-1:0]] - SUM_W'(ps_q);
		end
	end

	// magnitude operands
	assign re_sel = re_q[c_q[CH_W-1:0]];
	assign im_sel = im_q[c_q[CH_W-1:0]];
	always_comb begin
		case (step_q)
			3'd0:    begin op_a = ar_q[23:0];  op_b = ar_q[23:0];  end
			3'd1:    begin op_a = ar_q[47:24]; op_b = ar_q[23:0];  end
			3'd2:    begin op_a = ar_q[47:24]; op_b = ar_q[47:24]; end
			3'd3:    begin op_a = ai_q[23:0];  op_b = ai_q[23:0];  end
			3'd4:    begin op_a = ai_q[47:24]; op_b = ai_q[23:0];  end
			default: begin op_a = ai_q[47:24]; op_b = ai_q[47:24]; end
		endcase
	end
	assign prod_full = op_a * op_b;

	// cross terms count twice
	always_comb begin
		case (step_q)
			3'd1, 3'd4: sq_term = SQ_W'(prod_q) << 25;
			3'd2, 3'd5: sq_term = SQ_W'(prod_q) << 48;
			default:    sq_term = SQ_W'(prod_q);
		endcase
	end

	assign rb_sum = r_q + bit_q;
	assign ld_out = (state_q == B_OUT) && (!out_valid_q || out_ready);

	sbdm_div #(
		.DW (TOT_W),
		.VW (CHAN_CNT_W)
	) u_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tot_q),
		.divisor  (ent_q.chans),
		.busy     (avg_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign div_start = (state_q == B_NEXT) && (c_q + 1'b1 >= ent_q.chans);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (head.acc) state_q <= B_MUL;
						else if (head.last) state_q <= B_FIN;
					end
				end
				B_MUL:   state_q <= B_ACC;
				B_ACC:   state_q <= ent_q.last ? B_FIN : B_IDLE;
				B_FIN:   state_q <= (ent_q.kind == RES_MAG) ? B_MLOAD : B_OUT;
				B_MLOAD: state_q <= B_MMUL;
				B_MMUL:  state_q <= B_MADD;
				B_MADD:  state_q <= (step_q == 3'd5) ? B_SQ0 : B_MMUL;
				B_SQ0:   state_q <= (sq_q[SQ_W-1:94] != '0) ? B_NEXT : B_SQRT;
				B_SQRT:  if (bit_q == '0) state_q <= B_NEXT;
				B_NEXT:  state_q <= div_start ? B_DIV : B_MLOAD;
				B_DIV:   if (div_done) state_q <= B_OUT;
				B_OUT:   if (ld_out) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
		if (state_q == B_MUL) begin
			pc_q <= $signed(ent_q.x) * cos_v;
			ps_q <= $signed(ent_q.x) * sin_v;
		end
		if (state_q == B_FIN) begin
			c_q         <= '0;
			tot_q       <= '0;
			res_level_q <= '0;
			res_nyq_q   <= (ent_q.kind == RES_NYQ);
		end
		if (state_q == B_MLOAD) begin
			ar_q   <= re_sel[SUM_W-1] ? SUM_W'(0) - re_sel : re_sel;
			ai_q   <= im_sel[SUM_W-1] ? SUM_W'(0) - im_sel : im_sel;
			sq_q   <= '0;
			step_q <= '0;
		end
		if (state_q == B_MMUL) prod_q <= prod_full;
		if (state_q == B_MADD) begin
			sq_q   <= sq_q + sq_term;
			step_q <= step_q + 1'b1;
		end
		if (state_q == B_SQ0) begin
			y_q   <= sq_q[93:30];
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
			if (sq_q[SQ_W-1:94] != '0) tot_q <= tot_q + TOT_W'(32'hFFFF_FFFF);
		end
		// integer square root, one result bit per pass of bit_q
		if (state_q == B_SQRT) begin
			if (bit_q == '0) begin
				tot_q <= tot_q + TOT_W'(r_q[31:0]);
			end else begin
				if (y_q >= rb_sum) begin
					y_q <= y_q - rb_sum;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
		if (state_q == B_NEXT) c_q <= c_q + 1'b1;
		if (state_q == B_DIV && div_done) begin
			res_level_q <= (div_quot[TOT_W-1:LEVEL_W] != '0) ? {LEVEL_W{1'b1}}
			                                               : div_quot[LEVEL_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			level_q <= res_level_q;
			nyq_q   <= res_nyq_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign above_nyquist = nyq_q;

	assert property (@(posedge clk) disable iff (!arst_n) (state_q == B_ACC) |-> ent_q.acc)
		else $error("accumulate without a queued sample");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> (state_q == B_DIV))
		else $error("average finished outside its state");
	assert property (@(posedge clk) disable iff (!arst_n) avg_busy |-> (state_q == B_DIV))
		else $error("average divider running outside its state");
	assert property (@(posedge clk) disable iff (!arst_n) ld_out |=> out_valid_q)
		else $error("result load lost");

endmodule

@@ rtl/single_bin_dft_magnitude.sv @@
// Front end: a sample with an in-band bin runs a 35-step phase divide, and the
// first sample of a frame with a nonzero sample rate first runs a bin divide.
// The front end takes no new sample until the last one is queued; its divider is shared.
// Frame end: the squares and a 32-step square root for each channel, then a
// channel average divide, before the result appears.
// Reset: registers take their defaults, sums and positions clear at once.
// ---------------------------------------------------------------------------
// single_bin_dft_magnitude
// Single-bin DFT level meter over a multichannel audio frame.
// ---------------------------------------------------------------------------
module single_bin_dft_magnitude import sbdm_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_W-1:0]    level,
	output logic                  above_nyquist
);
	sbdm_cfg_t   cfg_q;
	logic        push;
	sbdm_entry_t push_data;
	logic        pop;
	sbdm_entry_t head;
	logic        full;
	logic        empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_freq   <= RST_TARGET_FREQ;
			cfg_q.sample_rate   <= RST_SAMPLE_RATE;
			cfg_q.frame_length  <= RST_FRAME_LENGTH;
			cfg_q.channel_count <= RST_CHANNEL_COUNT;
			cfg_q.interleaved   <= RST_INTERLEAVED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_FREQ:   cfg_q.target_freq   <= cfg_data[FREQ_W-1:0];
				CFG_SAMPLE_RATE:   cfg_q.sample_rate   <= cfg_data[RATE_W-1:0];
				CFG_FRAME_LENGTH:  cfg_q.frame_length  <= cfg_data[LEN_W-1:0];
				CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CFG_CNT_W-1:0];
				CFG_INTERLEAVED:   cfg_q.interleaved   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sbdm_front #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sbdm_fifo #(
		.W     ($bits(sbdm_entry_t)),
		.DEPTH (DEF_FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.full      (full),
		.empty     (empty)
	);

	sbdm_back #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.level         (level),
		.above_nyquist (above_nyquist)
	);

endmodule

@@ dv/sbdm_checker.sv @@
// ---------------------------------------------------------------------------
// sbdm_checker
// Watches the register port and both sample/result channels of the single-bin
// DFT magnitude block, predicts every frame level and compares results in order.
// ---------------------------------------------------------------------------
module sbdm_checker import sbdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [LEVEL_W-1:0]    level,
	input  logic                  above_nyquist,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               nyq;
	} level_t;

	level_t        level_q[$];
	logic [15:0]   quarter_wave [0:1024];
	sbdm_cfg_t     regs;
	logic [47:0]   re_sum [0:7];
	logic [47:0]   im_sum [0:7];
	int unsigned   smp_pos;
	int unsigned   chn_pos;
	int unsigned   bin_k;

	assign pending = level_q.size();

	// quarter sine, Taylor series in Q30 rounded to Q15
	initial begin
		longint unsigned th, x2, term;
		longint          acc;
		for (int i = 0; i <= 1024; i++) begin
			th   = (64'(i) * 64'd6746518852 + 64'd2048) >> 12;
			x2   = (th * th + (64'd1 << 29)) >> 30;
			term = th;
			acc  = longint'(th);
			for (int n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			quarter_wave[i] = 16'((64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
		end
	end

	function automatic longint sine_of(int unsigned idx);
		logic [11:0] p;
		longint      v;
		p = 12'(idx);
		v = p[10] ? longint'(quarter_wave[1024 - p[9:0]]) : longint'(quarter_wave[p[9:0]]);
		return p[11] ? -v : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned y);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > y) b = b >> 2;
		while (b != 0) begin
			if (y >= r + b) begin
				y = y - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned chan_mag(logic [47:0] re, logic [47:0] im);
		logic [63:0]  ar, ai;
		logic [127:0] sq;
		ar = re[47] ? 64'd0 - 64'($signed(re)) : 64'(re);
		ai = im[47] ? 64'd0 - 64'($signed(im)) : 64'(im);
		sq = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
		if ((sq >> 94) != 0) return 64'hFFFF_FFFF;
		return int_sqrt(64'(sq >> 30));
	endfunction

	task automatic clear_sums();
		for (int c = 0; c < 8; c++) begin
			re_sum[c] = '0;
			im_sum[c] = '0;
		end
		smp_pos = 0;
		chn_pos = 0;
	endtask

	// one accepted sample through the frame model
	task automatic predict_sample(logic [SAMPLE_W-1:0] raw);
		int unsigned     len, chans, ph, c;
		longint          x, cs, sn;
		longint unsigned k, tot, lvl;
		logic            done;
		level_t          r;
		len   = (regs.frame_length > FRAME_MAX) ? FRAME_MAX : regs.frame_length;
		chans = (regs.channel_count == 0) ? 1 : regs.channel_count;
		if (chans > 8) chans = 8;
		x     = longint'($signed(raw));
		done  = 1'b0;
		if (len == 0) begin
			clear_sums();
			level_q.push_back('{level: '0, nyq: 1'b0});
			return;
		end
		if (smp_pos >= len || chn_pos >= chans) clear_sums();
		// bin is latched at the first sample of a frame
		if (smp_pos == 0 && chn_pos == 0) begin
			k = 2 * FRAME_MAX;
			if (regs.sample_rate != 0) begin
				k = (64'(regs.target_freq) * len) / regs.sample_rate;
				if (k > 2 * FRAME_MAX) k = 2 * FRAME_MAX;
			end
			bin_k = int'(k);
			clear_sums();
		end
		if (bin_k <= (len >> 1)) begin
			c  = chn_pos;
			ph = (((64'(bin_k) * smp_pos) % len) * 4096 / len) & 4095;
			cs = sine_of((ph + 1024) & 4095);
			sn = sine_of(ph);
			re_sum[c] = re_sum[c] + 48'(x * cs);
			im_sum[c] = im_sum[c] - 48'(x * sn);
		end
		if (regs.interleaved) begin
			chn_pos++;
			if (chn_pos >= chans) begin
				chn_pos = 0;
				smp_pos++;
				if (smp_pos >= len) done = 1'b1;
			end
		end else begin
			smp_pos++;
			if (smp_pos >= len) begin
				smp_pos = 0;
				chn_pos++;
				if (chn_pos >= chans) done = 1'b1;
			end
		end
		if (!done) return;
		if (bin_k > (len >> 1)) begin
			r = '{level: '0, nyq: 1'b1};
		end else begin
			tot = 0;
			for (int i = 0; i < chans; i++) tot += chan_mag(re_sum[i], im_sum[i]);
			lvl = tot / chans;
			r   = '{level: (lvl > 64'h7FF_FFFF) ? 27'h7FF_FFFF : LEVEL_W'(lvl), nyq: 1'b0};
		end
		level_q.push_back(r);
		clear_sums();
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// register writes, sample transactions, result transactions
	always @(posedge clk or negedge arst_n) begin
		level_t want;
		if (!arst_n) begin
			regs <= '{RST_TARGET_FREQ, RST_SAMPLE_RATE, RST_FRAME_LENGTH,
				RST_CHANNEL_COUNT, RST_INTERLEAVED};
			clear_sums();
			bin_k = 0;
			level_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET_FREQ:   regs.target_freq   <= cfg_data[FREQ_W-1:0];
					CFG_SAMPLE_RATE:   regs.sample_rate   <= cfg_data[RATE_W-1:0];
					CFG_FRAME_LENGTH:  regs.frame_length  <= cfg_data[LEN_W-1:0];
					CFG_CHANNEL_COUNT: regs.channel_count <= cfg_data[CFG_CNT_W-1:0];
					CFG_INTERLEAVED:   regs.interleaved   <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_sample(sample);
			if (out_valid && out_ready) begin
				if (level_q.size() == 0) begin
					report_mismatch("unexpected result, level", level, -1);
				end else begin
					want = level_q.pop_front();
					if (level !== want.level) report_mismatch("level", level, want.level);
					if (above_nyquist !== want.nyq)
						report_mismatch("above_nyquist", above_nyquist, want.nyq);
				end
			end
		end
	end

endmodule

@@ dv/tb_single_bin_dft_magnitude.sv @@
// ---------------------------------------------------------------------------
// tb_single_bin_dft_magnitude
// Drives register settings and sample frames into the level meter under
// changing idle and stall patterns; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_single_bin_dft_magnitude;
	import sbdm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [LEVEL_W-1:0]    level;
	logic                  above_nyquist;
	int                    fail_count;
	int                    pending;
	int                    send_idle;
	int                    recv_stall;
	int                    cycles;
	int                    items_sent;
	bit                    hold_go;

	single_bin_dft_magnitude i_dut (.*);

	sbdm_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// timeout guard
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_single_bin_dft_magnitude failed");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	// settle the block, then load all five registers
	task automatic load_regs(int unsigned freq, int unsigned rate, int unsigned len,
			int unsigned chans, int unsigned il);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		write_reg(CFG_TARGET_FREQ, freq);
		write_reg(CFG_SAMPLE_RATE, rate);
		write_reg(CFG_FRAME_LENGTH, len);
		write_reg(CFG_CHANNEL_COUNT, chans);
		write_reg(CFG_INTERLEAVED, il);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] x);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		sample   <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic void pick_mode(int m);
		case (m % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 82; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 82; end
			default: begin send_idle = 24; recv_stall = 24; end
		endcase
	endfunction

	initial begin
		int unsigned rate, freq, len, chans, il, n;
		int          ph;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		sample     = '0;
		send_idle  = 0;
		recv_stall = 0;
		items_sent = 0;
		hold_go    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: in-band bin with full-scale and zero samples
		load_regs(2000, 8000, 8, 1, 1);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h5555);
		// zero frame length with zero channel count
		load_regs(0, 44100, 0, 0, 1);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		// zero sample rate saturates the bin
		load_regs(22000, 0, 2, 1, 1);
		send_sample(16'h1234);
		send_sample(16'hEDCB);
		// oversized channel count, channel after channel
		load_regs(32767, 1, 1, 15, 0);
		for (int i = 0; i < 8; i++) send_sample(rand_sample());
		// oversized frame, partial frame dropped by the next setting
		load_regs(0, 192000, 8191, 1, 1);
		for (int i = 0; i < 3; i++) send_sample(rand_sample());

		// long result hold-off while zero-length frames pile up
		load_regs(0, 262143, 0, 1, 0);
		hold_go = 1'b1;
		for (int i = 0; i < 24; i++) send_sample(rand_sample());

		// random phases of small frames
		ph = 0;
		while (items_sent < 380) begin
			pick_mode(ph);
			ph++;
			rate  = ($urandom_range(9) == 0) ? $urandom_range(0, 262143)
				: $urandom_range(1000, 192000);
			freq  = ($urandom_range(9) < 7) ? $urandom_range(0,
				(rate / 2 > 32767) ? 32767 : rate / 2) : $urandom_range(0, 32767);
			len   = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
			chans = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			il    = $urandom_range(1);
			load_regs(freq, rate, len, chans, il);
			n = ((chans == 0) ? 1 : (chans > 8 ? 8 : chans)) * ((len == 0) ? 1 : len);
			n = n * $urandom_range(1, 3) + (($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0);
			for (int i = 0; i < n; i++) begin
				// pause once until the block has drained
				if (ph == 3 && i == n / 2) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_sample(rand_sample());
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_single_bin_dft_magnitude passed");
		end else begin
			$display("tb_single_bin_dft_magnitude failed");
		end
		$finish;
	end

endmodule
